@@ hdl/tns_pkg.sv @@
package tns_pkg;

  localparam int NUM_TASKS   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int SLOT_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int WORD_W      = 32;

  localparam logic [2:0] OP_NOTIFY      = 3'd0;
  localparam logic [2:0] OP_WAIT        = 3'd1;
  localparam logic [2:0] OP_TAKE        = 3'd2;
  localparam logic [2:0] OP_RESUME_WAIT = 3'd3;
  localparam logic [2:0] OP_RESUME_TAKE = 3'd4;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_SET_BITS  = 3'd1;
  localparam logic [2:0] ACT_INCREMENT = 3'd2;
  localparam logic [2:0] ACT_OVERWRITE = 3'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        task_index;
    logic [WORD_W-1:0] notify_value;
    logic [2:0]        action;
    logic [WORD_W-1:0] entry_clear;
    logic [WORD_W-1:0] exit_clear;
    logic              take_clear;
    logic              no_wait;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] rd_value;
    logic              wake;
  } result_t;

  function automatic value_t word_to_value(logic [WORD_W-1:0] w);
    logic [63:0] tmp;
    tmp = 64'(w);
    return tmp[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] value_to_word(value_t v);
    logic [63:0] tmp;
    tmp = 64'(v);
    return tmp[WORD_W-1:0];
  endfunction

endpackage

@@ hdl/tns_if.sv @@
interface tns_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  task_index;
  logic [31:0] notify_value;
  logic [2:0]  action;
  logic [31:0] entry_clear;
  logic [31:0] exit_clear;
  logic        take_clear;
  logic        no_wait;

  modport source (
    output valid, op, task_index, notify_value, action, entry_clear, exit_clear,
           take_clear, no_wait,
    input  ready
  );
  modport sink (
    input  valid, op, task_index, notify_value, action, entry_clear, exit_clear,
           take_clear, no_wait,
    output ready
  );
endinterface

interface tns_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] rd_value;
  logic        wake;

  modport source (output valid, status, rd_value, wake, input ready);
  modport sink (input valid, status, rd_value, wake, output ready);
endinterface

@@ hdl/task_notification_slots_top.sv @@
// Sequencing: the accepted input word is registered, the slot read-modify-write
//   runs in the execute state and its result is registered for the response.
// Flow: no new word is taken until the result handshake; the controller steps
//   load, execute (slot read-modify-write) and respond for each word.
// Reset: synchronous, active low; clears every slot's value, pending and
//   waiting flags and returns the controller to idle.
module task_notification_slots_top
  import tns_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  tns_in_if.sink           in_chan,
  tns_out_if.source        out_chan
);

  dp_cmd_t cmd;
  item_t   item;
  result_t result;

  assign item = '{
    op:            in_chan.op,
    task_index:    in_chan.task_index,
    notify_value:  in_chan.notify_value,
    action:        in_chan.action,
    entry_clear:   in_chan.entry_clear,
    exit_clear:    in_chan.exit_clear,
    take_clear:    in_chan.take_clear,
    no_wait:       in_chan.no_wait
  };

  tns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  tns_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

  assign out_chan.status   = result.status;
  assign out_chan.rd_value = result.rd_value;
  assign out_chan.wake     = result.wake;

`ifndef SYNTH
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> cmd.exec)
    else $error("accepted word not executed");

  a_exec_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (out_chan.valid && !in_chan.ready))
    else $error("execute not followed by response");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input taken while result pending");

  a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.wake) |-> (out_chan.status == ST_OK))
    else $error("wake without ok status");
`endif

endmodule

@@ hdl/tns_ctrl.sv @@
module tns_ctrl
  import tns_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hdl/tns_datapath.sv @@
module tns_datapath
  import tns_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  dp_cmd_t cmd,
  input  item_t   item,
  output result_t result
);

  item_t   item_r;
  result_t result_r, result_nxt;

  value_t value_r [NUM_TASKS];
  logic [NUM_TASKS-1:0] pending_r;
  logic [NUM_TASKS-1:0] waiting_r;

  logic [SLOT_W-1:0] slot;
  logic              idx_ok;
  value_t            v_cur, v_nxt, nval;
  logic              p_cur, p_nxt, w_cur, w_nxt;
  logic              wr_en;

  assign slot   = SLOT_W'(item_r.task_index);
  assign idx_ok = (32'(item_r.task_index) < NUM_TASKS);
  assign v_cur  = value_r[slot];
  assign p_cur  = pending_r[slot];
  assign w_cur  = waiting_r[slot];
  assign nval   = word_to_value(item_r.notify_value);

  always_comb begin
    v_nxt      = v_cur;
    p_nxt      = p_cur;
    w_nxt      = w_cur;
    wr_en      = 1'b0;
    result_nxt = '{status: ST_INVALID, rd_value: '0, wake: 1'b0};
    if (idx_ok) begin
      unique case (item_r.op)
        OP_NOTIFY: begin
          if (item_r.action <= ACT_OVERWRITE) begin
            wr_en = 1'b1;
            unique case (item_r.action)
              ACT_SET_BITS:  v_nxt = v_cur | nval;
              ACT_INCREMENT: v_nxt = v_cur + value_t'(1);
              ACT_OVERWRITE: v_nxt = nval;
              default:       v_nxt = v_cur;
            endcase
            p_nxt             = 1'b1;
            result_nxt.status = ST_OK;
            if (w_cur) begin
              w_nxt           = 1'b0;
              result_nxt.wake = 1'b1;
            end
          end
        end
        OP_WAIT: begin
          wr_en = 1'b1;
          if (!p_cur) begin
            v_nxt = v_cur & ~word_to_value(item_r.entry_clear);
            if (item_r.no_wait) begin
              result_nxt.status = ST_TIMEOUT;
            end else begin
              w_nxt             = 1'b1;
              result_nxt.status = ST_BLOCKED;
            end
          end else begin
            result_nxt.rd_value = value_to_word(v_cur);
            v_nxt               = v_cur & ~word_to_value(item_r.exit_clear);
            p_nxt               = 1'b0;
            result_nxt.status   = ST_OK;
          end
        end
        OP_TAKE: begin
          wr_en = 1'b1;
          priority if (v_cur != '0) begin
            v_nxt             = item_r.take_clear ? '0 : v_cur - value_t'(1);
            p_nxt             = 1'b0;
            result_nxt.status = ST_OK;
          end else if (item_r.no_wait) begin
            result_nxt.status = ST_TIMEOUT;
          end else begin
            w_nxt             = 1'b1;
            result_nxt.status = ST_BLOCKED;
          end
        end
        OP_RESUME_WAIT: begin
          wr_en = 1'b1;
          if (w_cur) begin
            w_nxt             = 1'b0;
            result_nxt.status = ST_TIMEOUT;
          end else begin
            result_nxt.rd_value = value_to_word(v_cur);
            v_nxt               = v_cur & ~word_to_value(item_r.exit_clear);
            p_nxt               = 1'b0;
            result_nxt.status   = ST_OK;
          end
        end
        OP_RESUME_TAKE: begin
          wr_en = 1'b1;
          if (w_cur) begin
            w_nxt             = 1'b0;
            result_nxt.status = ST_TIMEOUT;
          end else begin
            priority if (item_r.take_clear) begin
              v_nxt = '0;
            end else if (v_cur != '0) begin
              v_nxt = v_cur - value_t'(1);
            end else begin
              v_nxt = v_cur;
            end
            p_nxt             = 1'b0;
            result_nxt.status = ST_OK;
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
    end
    if (cmd.exec) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        value_r[i] <= '0;
      end
      pending_r <= '0;
      waiting_r <= '0;
    end else if (cmd.exec && wr_en) begin
      value_r[slot]   <= v_nxt;
      pending_r[slot] <= p_nxt;
      waiting_r[slot] <= w_nxt;
    end
  end

  assign result = result_r;

endmodule
